// ===== hw/rtl/ccfr_pkg.sv =====
// Shared types, constants and a function for the ccTalk reply frame receiver.
`default_nettype none

package ccfr_pkg;

   // Configuration port geometry and register map
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [0:0] REG_POLL_HEADER = 1'b0;
   localparam logic [7:0] POLL_HEADER_RESET = 8'd229;

   // Stream payload widths
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 48;

   // Item action codes
   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_CMD_SENT = 1'b1;

   // Parser states; code 7 is unused and falls back to destination
   typedef enum logic [2:0] {
      ST_DST    = 3'd0,
      ST_LEN    = 3'd1,
      ST_SRC    = 3'd2,
      ST_HDR    = 3'd3,
      ST_DATA   = 3'd4,
      ST_SUM    = 3'd5,
      ST_FINISH = 3'd6
   } parse_state_type;

   // Parser to credit unit: a good frame is complete on this transfer
   typedef struct packed {
      logic       run;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [7:0] sent_header;
   } credit_req_type;

   // Credit unit result after this transfer
   typedef struct packed {
      logic [31:0] balance;
      logic [7:0]  event_count;
      logic        updated;
   } credit_rsp_type;

   // Coin code to credit units
   function automatic logic [3:0] coin_multiplier(input logic [7:0] code);
      logic [3:0] mult;
      case (code)
         8'd3, 8'd4: mult = 4'd2;
         8'd5, 8'd6: mult = 4'd5;
         8'd7, 8'd8: mult = 4'd10;
         default:    mult = 4'd1;
      endcase
      return mult;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ccfr_parser.sv =====
// Reply frame parser: state walk, running checksum and captured data bytes.
`default_nettype none

module ccfr_parser
   import ccfr_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           accept,
   input  wire logic           action,
   input  wire logic [7:0]     byte_value,
   input  wire logic [7:0]     command_header,
   output      logic           frame_done,
   output      logic           checksum_bad,
   output      credit_req_type credit_req
);

   parse_state_type state_ff, state_in;
   logic [7:0] data_length_ff, data_length_in;
   logic [7:0] data_index_ff, data_index_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] second_ff, second_in;
   logic [7:0] sent_header_ff, sent_header_in;
   logic [7:0] index_step;
   logic [7:0] sum_add;

   assign sum_add = sum_ff + byte_value;
   // index saturates at 255
   assign index_step = (data_index_ff != 8'hFF) ? (data_index_ff + 8'd1) : data_index_ff;

   // Next parser state and checksum
   always_comb begin
      state_in       = state_ff;
      data_length_in = data_length_ff;
      data_index_in  = data_index_ff;
      sum_in         = sum_ff;
      first_in       = first_ff;
      second_in      = second_ff;
      sent_header_in = sent_header_ff;
      checksum_bad   = 1'b0;
      if (accept) begin
         if (action == ACT_CMD_SENT) begin
            sent_header_in = command_header;
            state_in       = ST_DST;
         end else begin
            case (state_ff)
               ST_DST: begin
                  data_index_in = 8'd0;
                  sum_in        = byte_value;
                  state_in      = ST_LEN;
               end
               ST_LEN: begin
                  data_length_in = byte_value;
                  sum_in         = sum_add;
                  state_in       = ST_SRC;
               end
               ST_SRC: begin
                  sum_in   = sum_add;
                  state_in = ST_HDR;
               end
               ST_HDR: begin
                  sum_in   = sum_add;
                  state_in = (data_length_ff == 8'd0) ? ST_SUM : ST_DATA;
               end
               ST_DATA: begin
                  if (data_index_ff == 8'd0) begin
                     first_in = byte_value;
                  end else if (data_index_ff == 8'd1) begin
                     second_in = byte_value;
                  end
                  sum_in        = sum_add;
                  data_index_in = index_step;
                  if (index_step >= data_length_ff) begin
                     state_in = ST_SUM;
                  end
               end
               ST_SUM: begin
                  sum_in = sum_add;
                  if (sum_add == 8'd0) begin
                     state_in = ST_FINISH;
                  end else begin
                     state_in     = ST_DST;
                     checksum_bad = 1'b1;
                  end
               end
               ST_FINISH: begin
                  state_in = ST_FINISH;
               end
               default: begin
                  state_in = ST_DST;
               end
            endcase
         end
      end
   end

   // Frame status and credit request for this transfer
   always_comb begin
      frame_done              = accept && (action == ACT_BYTE) && (state_in == ST_FINISH);
      credit_req.run          = frame_done;
      credit_req.first_byte   = first_ff;
      credit_req.second_byte  = second_ff;
      credit_req.sent_header  = sent_header_ff;
   end

   // Parser registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_DST;
         data_length_ff <= 8'd0;
         data_index_ff  <= 8'd0;
         sum_ff         <= 8'd0;
         first_ff       <= 8'd0;
         second_ff      <= 8'd0;
         sent_header_ff <= 8'd0;
      end else begin
         state_ff       <= state_in;
         data_length_ff <= data_length_in;
         data_index_ff  <= data_index_in;
         sum_ff         <= sum_in;
         first_ff       <= first_in;
         second_ff      <= second_in;
         sent_header_ff <= sent_header_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ccfr_credit.sv =====
// Buffered credit accounting: event counter tracking and balance update.
`default_nettype none

module ccfr_credit
   import ccfr_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic [7:0]     poll_header,
   input  wire credit_req_type credit_req,
   output      credit_rsp_type credit_rsp
);

   logic [7:0]  event_ff, event_in;
   logic        pending_ff, pending_in;
   logic [31:0] balance_ff, balance_in;
   logic        updated;

   // Counter compare and balance add
   always_comb begin
      event_in   = event_ff;
      pending_in = pending_ff;
      balance_in = balance_ff;
      updated    = 1'b0;
      if (credit_req.run && (credit_req.sent_header == poll_header)) begin
         if (pending_ff) begin
            // first good frame only seeds the counter
            pending_in = 1'b0;
            event_in   = credit_req.first_byte;
         end else if (event_ff != credit_req.first_byte) begin
            event_in   = credit_req.first_byte;
            balance_in = balance_ff
                       + {28'd0, coin_multiplier(credit_req.second_byte)};
            updated    = 1'b1;
         end
      end
   end

   assign credit_rsp.balance     = balance_in;
   assign credit_rsp.event_count = event_in;
   assign credit_rsp.updated     = updated;

   // Credit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         event_ff   <= 8'd0;
         pending_ff <= 1'b1;
         balance_ff <= 32'd0;
      end else begin
         event_ff   <= event_in;
         pending_ff <= pending_in;
         balance_ff <= balance_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/cctalk_reply_frame_receiver.sv =====
// Top level of the ccTalk reply frame receiver: streams, CSR port, result register.
//
// Channel  | Direction | Handshake            | Payload
// req_*    | in        | tvalid/tready        | tuser: action; tdata: byte, header
// rsp_*    | out       | tvalid/tready        | tdata: done, bad, balance, event, upd
// csr_*    | in        | psel/penable/pready  | credit_poll_header at address 0
//
// One item per cycle while the output is not stalled: the parser and credit logic run in
// the cycle of the input transfer and the result is registered into the output register.
// The input is ready whenever the output register is empty or being drained.
// Synchronous active-high reset returns the parser to destination, clears
// the balance and restores the poll header to 229.
`default_nettype none

module cctalk_reply_frame_receiver
   import ccfr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input stream
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // [7:0] byte_value, [15:8] command_header
   input  wire logic [0:0]            req_tuser,  // [0] action
   // result stream
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,  // [0] frame_done, [1] checksum_bad,
                                                  // [33:2] credit_balance,
                                                  // [41:34] event_count,
                                                  // [42] balance_updated, [47:43] zero
   // configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);

   logic           accept;
   logic           frame_done;
   logic           checksum_bad;
   credit_req_type credit_req;
   credit_rsp_type credit_rsp;
   logic [7:0]     poll_header_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [42:0]    rsp_data_ff;

   // Input transfer
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_POLL_HEADER)
                     ? {24'd0, poll_header_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_header_ff <= POLL_HEADER_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[2] == REG_POLL_HEADER)) begin
         poll_header_ff <= csr_pwdata[7:0];
      end
   end

   ccfr_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .action         (req_tuser[0]),
      .byte_value     (req_tdata[7:0]),
      .command_header (req_tdata[15:8]),
      .frame_done     (frame_done),
      .checksum_bad   (checksum_bad),
      .credit_req     (credit_req)
   );

   ccfr_credit u_credit (
      .clock       (clock),
      .reset       (reset),
      .poll_header (poll_header_ff),
      .credit_req  (credit_req),
      .credit_rsp  (credit_rsp)
   );

   // Result register
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= {credit_rsp.updated, credit_rsp.event_count,
                         credit_rsp.balance, checksum_bad, frame_done};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};

endmodule

`default_nettype wire

// ===== sim/ccfr_reply_checker.sv =====
// Checker for the ccTalk reply frame receiver: tracks the CSR, predicts and compares results.
`default_nettype none

module ccfr_reply_checker
   import ccfr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // [7:0] byte_value, [15:8] command_header
   input  wire logic [0:0]            req_tuser,  // [0] action
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,  // [0] done, [1] bad, [33:2] balance,
                                                  // [41:34] event, [42] updated
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   input  wire logic [CSR_DATA_W-1:0] csr_prdata,
   input  wire logic                  csr_pready,
   output int                         errors,
   output int                         pending
);

   localparam logic [CSR_ADDR_W-1:0] POLL_HDR_ADDR = CSR_ADDR_W'(4 * REG_POLL_HEADER);

   typedef struct packed {
      logic        done;
      logic        bad;
      logic [31:0] bal;
      logic [7:0]  ev;
      logic        upd;
   } reply_type;

   // Shadow copy of the receiver state
   logic [7:0]      poll_hdr;
   parse_state_type rx_state;
   logic [7:0]      len_field;
   logic [7:0]      idx;
   logic [7:0]      sum;
   logic [7:0]      data0;
   logic [7:0]      data1;
   logic [7:0]      last_cmd;
   logic [7:0]      ev_count;
   logic            first_pending;
   logic [31:0]     bal;

   reply_type reply_q[$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // Advance the shadow parser by one transfer and return the reply it should give
   function automatic reply_type predict_reply(input logic act, input logic [7:0] b,
                                               input logic [7:0] hdr);
      reply_type r;
      r = '0;
      if (act == ACT_CMD_SENT) begin
         last_cmd = hdr;
         rx_state = ST_DST;
      end else begin
         case (rx_state)
            ST_DST: begin
               idx      = 8'd0;
               sum      = b;
               rx_state = ST_LEN;
            end
            ST_LEN: begin
               len_field = b;
               sum       = sum + b;
               rx_state  = ST_SRC;
            end
            ST_SRC: begin
               sum      = sum + b;
               rx_state = ST_HDR;
            end
            ST_HDR: begin
               sum      = sum + b;
               rx_state = (len_field == 8'd0) ? ST_SUM : ST_DATA;
            end
            ST_DATA: begin
               // only the first two data bytes are kept
               if (idx == 8'd0) data0 = b;
               else if (idx == 8'd1) data1 = b;
               sum = sum + b;
               if (idx != 8'd255) idx = idx + 8'd1;
               if (idx >= len_field) rx_state = ST_SUM;
            end
            ST_SUM: begin
               sum = sum + b;
               if (sum == 8'd0) begin
                  rx_state = ST_FINISH;
               end else begin
                  rx_state = ST_DST;
                  r.bad    = 1'b1;
               end
            end
            ST_FINISH: ;
            default: rx_state = ST_DST;
         endcase
         // credit accounting on every transfer that leaves the parser in finish
         if (rx_state == ST_FINISH) begin
            r.done = 1'b1;
            if (last_cmd == poll_hdr) begin
               if (first_pending) begin
                  first_pending = 1'b0;
                  ev_count      = data0;
               end else if (ev_count != data0) begin
                  ev_count = data0;
                  case (data1)
                     8'd3, 8'd4: bal = bal + 32'd2;
                     8'd5, 8'd6: bal = bal + 32'd5;
                     8'd7, 8'd8: bal = bal + 32'd10;
                     default:    bal = bal + 32'd1;
                  endcase
                  r.upd = 1'b1;
               end
            end
         end
      end
      r.bal = bal;
      r.ev  = ev_count;
      return r;
   endfunction

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         poll_hdr      = POLL_HEADER_RESET;
         rx_state      = ST_DST;
         len_field     = 8'd0;
         idx           = 8'd0;
         sum           = 8'd0;
         data0         = 8'd0;
         data1         = 8'd0;
         last_cmd      = 8'd0;
         ev_count      = 8'd0;
         first_pending = 1'b1;
         bal           = 32'd0;
         reply_q.delete();
      end else begin
         // result transfer: compare with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (reply_q.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata[31:0], 32'd0);
            end else begin
               want = reply_q.pop_front();
               if (rsp_tdata[0] !== want.done)
                  report_mismatch("frame_done", 32'(rsp_tdata[0]), 32'(want.done));
               if (rsp_tdata[1] !== want.bad)
                  report_mismatch("checksum_bad", 32'(rsp_tdata[1]), 32'(want.bad));
               if (rsp_tdata[33:2] !== want.bal)
                  report_mismatch("credit_balance", rsp_tdata[33:2], want.bal);
               if (rsp_tdata[41:34] !== want.ev)
                  report_mismatch("event_count", 32'(rsp_tdata[41:34]), 32'(want.ev));
               if (rsp_tdata[42] !== want.upd)
                  report_mismatch("balance_updated", 32'(rsp_tdata[42]), 32'(want.upd));
            end
         end
         // register access phase
         if (csr_psel && csr_penable && csr_pready && csr_paddr == POLL_HDR_ADDR) begin
            if (csr_pwrite) begin
               poll_hdr = csr_pwdata[7:0];
            end else if (csr_prdata !== {24'd0, poll_hdr}) begin
               report_mismatch("poll header readback", csr_prdata, {24'd0, poll_hdr});
            end
         end
         // input transfer
         if (req_tvalid && req_tready)
            reply_q.push_back(predict_reply(req_tuser[0], req_tdata[7:0], req_tdata[15:8]));
      end
      pending <= reply_q.size();
   end

endmodule

`default_nettype wire

// ===== sim/cctalk_reply_frame_receiver_test.sv =====
// Testbench top for the ccTalk reply frame receiver: stimulus, CSR phases and verdict.
`default_nettype none

module cctalk_reply_frame_receiver_test;
   import ccfr_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] POLL_HDR_ADDR = CSR_ADDR_W'(4 * REG_POLL_HEADER);
   localparam int PHASE_ITEMS = 280;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [7:0] byte_value, [15:8] command_header
   logic [0:0]            req_tuser = '0;   // [0] action
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [0] done, [1] bad, [33:2] balance,
                                            // [41:34] event, [42] updated
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int         errors;
   int         pending;
   int         items_sent = 0;
   bit         no_idle = 1'b0;
   logic [7:0] poll_hdr = POLL_HEADER_RESET;
   logic [7:0] last_ev = 8'd0;

   cctalk_reply_frame_receiver u_top (.*);

   ccfr_reply_checker u_checker (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // receiver side stalls
   always @(posedge clock) begin
      rsp_tready <= no_idle || ($urandom_range(0, 99) >= 37);
   end

   // one input transfer, with random idle cycles ahead of it
   task automatic push_item(input logic act, input logic [7:0] b, input logic [7:0] hdr);
      while (!no_idle && $urandom_range(0, 99) < 37) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {hdr, b};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic push_byte(input logic [7:0] b);
      push_item(ACT_BYTE, b, 8'($urandom));
   endtask

   task automatic send_cmd(input logic [7:0] hdr);
      push_item(ACT_CMD_SENT, 8'($urandom), hdr);
   endtask

   // complete reply frame; a corrupt one gets a nonzero checksum offset
   task automatic send_frame(input int len, input logic [7:0] ev, input logic [7:0] code,
                             input bit corrupt);
      logic [7:0] sum;
      logic [7:0] bt;
      sum = 8'd0;
      for (int i = -3; i <= len; i++) begin
         if (i == -3) bt = 8'($urandom);
         else if (i == -2) bt = 8'(len);
         else if (i == -1) bt = 8'($urandom);
         else if (i == 0) bt = 8'($urandom);
         else if (i == 1) bt = ev;
         else if (i == 2) bt = code;
         else bt = 8'($urandom);
         sum = sum + bt;
         push_byte(bt);
      end
      bt = 8'd0 - sum;
      if (corrupt) bt = bt + 8'($urandom_range(1, 255));
      push_byte(bt);
   endtask

   // stop driving and let every expected result drain
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // setup and access phase, then back to idle
   task automatic csr_access(input logic wr, input logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= wr;
      csr_paddr   <= POLL_HDR_ADDR;
      csr_pwdata  <= {24'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // mostly well-formed command/reply exchanges, some broken frames and noise
   task automatic random_traffic(input int target);
      int r;
      int len;
      logic [7:0] ev;
      while (items_sent < target) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            send_cmd(($urandom_range(0, 99) < 80) ? poll_hdr : 8'($urandom));
            repeat ($urandom_range(1, 2)) begin
               if ($urandom_range(0, 199) == 0) len = $urandom_range(200, 255);
               else if ($urandom_range(0, 99) < 60) len = 2;
               else len = $urandom_range(0, 6);
               ev = ($urandom_range(0, 99) < 60) ? 8'($urandom) : last_ev;
               last_ev = ev;
               send_frame(len, ev,
                          ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 9)) :
                                                         8'($urandom),
                          $urandom_range(0, 99) < 15);
            end
            // bytes that arrive after the frames; the parser sits in finish if the last one was good
            repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
         end else if (r < 85) begin
            // truncated frame cut off by the next command
            send_cmd(poll_hdr);
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
         end else begin
            repeat ($urandom_range(1, 8)) begin
               push_item(($urandom_range(0, 9) == 0) ? ACT_CMD_SENT : ACT_BYTE,
                         8'($urandom), 8'($urandom));
            end
         end
      end
   endtask

   initial begin
      logic [7:0] phase_hdr[4];
      phase_hdr[0] = 8'h00;
      phase_hdr[1] = 8'hFF;
      phase_hdr[2] = 8'($urandom);
      phase_hdr[3] = POLL_HEADER_RESET;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(1'b0, 8'd0);

      // directed: first poll only records, later one adds, then a corrupt frame after another header
      send_cmd(POLL_HEADER_RESET);
      send_frame(2, 8'h00, 8'h07, 1'b0);
      push_byte(8'hFF);
      send_cmd(POLL_HEADER_RESET);
      send_frame(2, 8'hFF, 8'h03, 1'b0);
      send_cmd(8'h00);
      send_frame(0, 8'h00, 8'h00, 1'b1);
      last_ev = 8'hFF;

      random_traffic(PHASE_ITEMS);
      for (int p = 0; p < 4; p++) begin
         drain();
         poll_hdr = phase_hdr[p];
         csr_access(1'b1, poll_hdr);
         csr_access(1'b0, 8'd0);
         no_idle = (p == 1);
         random_traffic(PHASE_ITEMS * (p + 2));
      end
      no_idle = 1'b0;
      drain();
      repeat (10) @(posedge clock);

      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
